// ===== design/lmt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmt_pkg: shared types and constants of the line maximum tree
// Node pool size, operation codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package lmt_pkg;

    localparam int NODES = 1024;
    localparam int IDX_W = $clog2(NODES);
    localparam int CNT_W = $clog2(NODES + 1);
    localparam int RNG_W = 34;
    localparam int TAG_W = 3;

    localparam logic signed [63:0] EMPTY_B = -64'sh3f2f1f0f3f2f1f0f;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [0:0] REG_DOMAIN_LOW  = 1'b0;
    localparam logic [0:0] REG_DOMAIN_HIGH = 1'b1;

    // Evaluation tags: bit 0 picks the carried line, bits 2:1 the point
    localparam logic [TAG_W-1:0] TAG_LAST_INS = 3'd5;
    localparam logic [TAG_W-1:0] TAG_QUERY    = 3'd6;

    localparam logic [1:0] PT_LO  = 2'd0;
    localparam logic [1:0] PT_HI  = 2'd1;
    localparam logic [1:0] PT_MID = 2'd2;
    localparam logic [1:0] PT_X   = 2'd3;

    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 72;

    typedef struct packed {
        logic             clear;
        logic             rd;
        logic             ev_valid;
        logic [TAG_W-1:0] ev_tag;
        logic             dec;
        logic             ins_wr;
        logic             new_wr;
        logic             q_step;
        logic             out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       fits;
        logic       full;
        logic       child_zero;
        logic       q_last;
    } sts_t;

endpackage

// ===== design/lmt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmt_ctrl: sequencer of the line maximum tree
// Walks one tree path per insert or query item, issuing reads, evaluations and writes.
// ----------------------------------------------------------------------------
module lmt_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_xfer,
    output logic           in_ready,
    input  logic           m_tready,
    output logic           m_tvalid,
    input  lmt_pkg::sts_t  sts,
    output lmt_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DISP, S_CLR, S_RD, S_EVAL, S_WAIT, S_DEC, S_WR, S_NEW,
        S_QEV, S_QWAIT, S_QSTEP, S_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic [lmt_pkg::TAG_W-1:0]   cnt_reg, cnt_next;
    logic                        valid_reg, valid_next;

    assign in_ready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;

    // Command decode and next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg & ~m_tready;
        cmd        = '0;
        case (state_reg)
            S_INIT: begin
                cmd.clear  = 1'b1;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (in_xfer) begin
                    state_next = S_DISP;
                end
            end
            // Dispatch on the captured operation
            S_DISP: begin
                case (sts.func)
                    lmt_pkg::FUNC_INSERT: state_next = S_RD;
                    lmt_pkg::FUNC_QUERY:  state_next = S_RD;
                    lmt_pkg::FUNC_CLEAR:  state_next = S_CLR;
                    default:              state_next = S_DONE;
                endcase
            end
            S_CLR: begin
                cmd.clear  = 1'b1;
                state_next = S_DONE;
            end
            S_RD: begin
                cmd.rd   = 1'b1;
                cnt_next = '0;
                state_next = (sts.func == lmt_pkg::FUNC_QUERY) ? S_QEV : S_EVAL;
            end
            S_EVAL: begin
                cmd.ev_valid = 1'b1;
                cmd.ev_tag   = cnt_reg;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == lmt_pkg::TAG_LAST_INS) state_next = S_WAIT;
            end
            S_WAIT: state_next = S_DEC;
            S_DEC: begin
                cmd.dec    = 1'b1;
                state_next = S_WR;
            end
            S_WR: begin
                cmd.ins_wr = 1'b1;
                if (sts.fits || (sts.child_zero && sts.full)) state_next = S_DONE;
                else if (sts.child_zero) state_next = S_NEW;
                else state_next = S_RD;
            end
            S_NEW: begin
                cmd.new_wr = 1'b1;
                state_next = S_RD;
            end
            S_QEV: begin
                cmd.ev_valid = 1'b1;
                cmd.ev_tag   = lmt_pkg::TAG_QUERY;
                state_next   = S_QWAIT;
            end
            S_QWAIT: state_next = S_QSTEP;
            S_QSTEP: begin
                cmd.q_step = 1'b1;
                state_next = sts.q_last ? S_DONE : S_RD;
            end
            S_DONE: begin
                if (!valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== design/lmt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmt_dp: datapath of the line maximum tree
// Node memory, path range, line evaluation pipeline and result register.
// ----------------------------------------------------------------------------
module lmt_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_xfer,
    input  logic [0:0]                        cfg_addr,
    input  logic [31:0]                       cfg_data,
    input  logic [lmt_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                              in_xfer,
    input  lmt_pkg::cmd_t                     cmd,
    output lmt_pkg::sts_t                     sts,
    output logic [lmt_pkg::M_DATA_W-1:0]      m_tdata
);

    localparam int IW = lmt_pkg::IDX_W;
    localparam int RW = lmt_pkg::RNG_W;

    // Node memory
    logic signed [31:0] mem_slope [lmt_pkg::NODES];
    logic signed [63:0] mem_icpt  [lmt_pkg::NODES];
    logic [IW-1:0]      mem_left  [lmt_pkg::NODES];
    logic [IW-1:0]      mem_right [lmt_pkg::NODES];

    logic signed [31:0] rd_slope;
    logic signed [63:0] rd_icpt;
    logic [IW-1:0]      rd_left, rd_right;

    // Registers
    logic signed [31:0] dom_lo_reg, dom_hi_reg;
    logic signed [RW-1:0] root_lo_reg, root_hi_reg, lo_reg, hi_reg, mid_reg;
    logic [1:0]         func_reg;
    logic signed [31:0] car_slope_reg;
    logic signed [63:0] car_icpt_reg;
    logic signed [RW-1:0] x_reg;
    logic [IW-1:0]      node_reg;
    logic [lmt_pkg::CNT_W-1:0] used_reg;
    logic signed [63:0] best_reg;
    logic               st_reg;
    logic               swap_reg, fits_reg, right_reg;
    logic signed [63:0] val_reg [7];
    logic signed [65:0] prod_reg;
    logic signed [63:0] b_reg;
    logic [lmt_pkg::TAG_W-1:0] tag_reg;
    logic               pv_reg;
    logic [lmt_pkg::M_DATA_W-1:0] out_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dom_lo_reg <= 32'sh8000_0000;
            dom_hi_reg <= 32'sh7fff_ffff;
        end else if (cfg_xfer) begin
            case (cfg_addr)
                lmt_pkg::REG_DOMAIN_LOW:  dom_lo_reg <= cfg_data;
                lmt_pkg::REG_DOMAIN_HIGH: dom_hi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Midpoint, truncated toward zero
    logic signed [RW:0] sum;
    always_comb sum = {lo_reg[RW-1], lo_reg} + {hi_reg[RW-1], hi_reg};

    // Evaluation operands
    logic signed [31:0] ev_slope;
    logic signed [63:0] ev_icpt;
    logic signed [RW-1:0] ev_pt;
    always_comb begin
        ev_slope = cmd.ev_tag[0] ? car_slope_reg : rd_slope;
        ev_icpt  = cmd.ev_tag[0] ? car_icpt_reg : rd_icpt;
        case (cmd.ev_tag[2:1])
            lmt_pkg::PT_LO:  ev_pt = lo_reg;
            lmt_pkg::PT_HI:  ev_pt = hi_reg;
            lmt_pkg::PT_MID: ev_pt = mid_reg;
            lmt_pkg::PT_X:   ev_pt = x_reg;
            default:         ev_pt = x_reg;
        endcase
    end

    // Insert decision from the six evaluations
    logic               swap_c, fits_c, right_c;
    logic signed [63:0] l_hi, h_hi, l_mid, h_mid;
    always_comb begin
        swap_c = val_reg[0] > val_reg[1];
        l_hi   = swap_c ? val_reg[3] : val_reg[2];
        h_hi   = swap_c ? val_reg[2] : val_reg[3];
        l_mid  = swap_c ? val_reg[5] : val_reg[4];
        h_mid  = swap_c ? val_reg[4] : val_reg[5];
        fits_c = l_hi <= h_hi;
        right_c = l_mid < h_mid;
    end

    // Low and high lines after the swap
    logic signed [31:0] ls, hs;
    logic signed [63:0] lb, hb;
    logic [IW-1:0]      child;
    logic               child_zero, full;
    always_comb begin
        ls = swap_reg ? car_slope_reg : rd_slope;
        lb = swap_reg ? car_icpt_reg : rd_icpt;
        hs = swap_reg ? rd_slope : car_slope_reg;
        hb = swap_reg ? rd_icpt : car_icpt_reg;
        child = right_reg ? rd_right : rd_left;
        child_zero = (child == '0);
        full = (used_reg == lmt_pkg::CNT_W'(lmt_pkg::NODES));
    end

    // Query step
    logic               go_left;
    logic [IW-1:0]      q_child;
    always_comb begin
        go_left = x_reg <= mid_reg;
        q_child = go_left ? rd_left : rd_right;
    end

    assign sts.func       = func_reg;
    assign sts.fits       = fits_reg;
    assign sts.full       = full;
    assign sts.child_zero = child_zero;
    assign sts.q_last     = (q_child == '0);

    // Memory port
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            mem_slope[0] <= '0;
            mem_icpt[0]  <= lmt_pkg::EMPTY_B;
            mem_left[0]  <= '0;
            mem_right[0] <= '0;
        end else if (cmd.ins_wr) begin
            mem_slope[node_reg] <= (fits_reg || right_reg) ? hs : ls;
            mem_icpt[node_reg]  <= (fits_reg || right_reg) ? hb : lb;
            mem_left[node_reg]  <= (!fits_reg && !right_reg && child_zero && !full)
                                   ? used_reg[IW-1:0] : rd_left;
            mem_right[node_reg] <= (!fits_reg && right_reg && child_zero && !full)
                                   ? used_reg[IW-1:0] : rd_right;
        end else if (cmd.new_wr) begin
            mem_slope[node_reg] <= '0;
            mem_icpt[node_reg]  <= lmt_pkg::EMPTY_B;
            mem_left[node_reg]  <= '0;
            mem_right[node_reg] <= '0;
        end
        if (cmd.rd) begin
            rd_slope <= mem_slope[node_reg];
            rd_icpt  <= mem_icpt[node_reg];
            rd_left  <= mem_left[node_reg];
            rd_right <= mem_right[node_reg];
        end
    end

    // Evaluation pipeline: multiply, then add
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else begin
            pv_reg <= cmd.ev_valid;
        end
        prod_reg <= ev_slope * ev_pt;
        b_reg    <= ev_icpt;
        tag_reg  <= cmd.ev_tag;
        if (pv_reg) begin
            val_reg[tag_reg] <= prod_reg[63:0] + b_reg;
        end
    end

    // Walk state
    always_ff @(posedge aclk) begin
        mid_reg <= sum[RW:1] + RW'(sum[RW] & sum[0]);
        if (!aresetn) begin
            used_reg <= '0;
        end else if (cmd.clear) begin
            used_reg <= lmt_pkg::CNT_W'(1);
        end else if (cmd.new_wr) begin
            used_reg <= used_reg + 1'b1;
        end
        if (cmd.clear) begin
            root_lo_reg <= RW'(dom_lo_reg);
            root_hi_reg <= RW'(dom_hi_reg);
        end
        if (in_xfer) begin
            func_reg      <= s_tdata[1:0];
            car_slope_reg <= s_tdata[33:2];
            car_icpt_reg  <= 64'(signed'(s_tdata[94:34]));
            x_reg         <= RW'(signed'(s_tdata[126:95]));
            lo_reg        <= root_lo_reg;
            hi_reg        <= root_hi_reg;
            node_reg      <= '0;
            best_reg      <= lmt_pkg::EMPTY_B;
            st_reg        <= 1'b0;
        end
        if (cmd.dec) begin
            swap_reg  <= swap_c;
            fits_reg  <= fits_c;
            right_reg <= right_c;
        end
        if (cmd.ins_wr && !fits_reg) begin
            car_slope_reg <= right_reg ? ls : hs;
            car_icpt_reg  <= right_reg ? lb : hb;
            if (right_reg) lo_reg <= mid_reg + 1'b1;
            else hi_reg <= mid_reg;
            node_reg <= child_zero ? used_reg[IW-1:0] : child;
            st_reg   <= child_zero && full;
        end
        if (cmd.q_step) begin
            if (val_reg[6] > best_reg) best_reg <= val_reg[6];
            if (go_left) hi_reg <= mid_reg;
            else lo_reg <= mid_reg + 1'b1;
            node_reg <= q_child;
        end
        if (cmd.out_load) begin
            out_reg <= {7'd0, (func_reg == lmt_pkg::FUNC_INSERT) & st_reg,
                        (func_reg == lmt_pkg::FUNC_QUERY) ? best_reg : 64'sd0};
        end
    end

    assign m_tdata = out_reg;

endmodule

// ===== design/line_max_tree.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_max_tree: upper envelope of lines in a tree over an integer range
// Insert, maximum query and clear over a pool of tree nodes.
// ----------------------------------------------------------------------------
// channel   direction  payload
// s_*       in         func, slope, intercept, point_x
// m_*       out        best value, status
// cfg_*     in         register index, 32-bit value
//
// An insert handles each tree level with a node read, six line evaluations
// through one multiplier, a settle state, decision and write, plus an
// allocation where a child node is made; a query reads, evaluates, settles
// and steps per level; paths run up to 33 levels. Each item adds dispatch
// and output states. After reset the empty root is written before items
// are taken. A finished result waits in the output register; the next item
// is taken meanwhile; the block holds only when that item completes first.
// ----------------------------------------------------------------------------
module line_max_tree (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // func[1:0], slope[33:2], intercept[94:34], point_x[126:95], zero
    input  logic [lmt_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // best value[63:0], status[64], zero
    output logic [lmt_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [0:0]                    cfg_addr,
    input  logic [31:0]                   cfg_data
);

    lmt_pkg::cmd_t cmd;
    lmt_pkg::sts_t sts;
    logic          in_xfer;

    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid & s_tready;

    lmt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_xfer  (in_xfer),
        .in_ready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    lmt_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_xfer (cfg_valid & cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .in_xfer  (in_xfer),
        .cmd      (cmd),
        .sts      (sts),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== dv/line_max_tree_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_max_tree_tb: self-checking bench for the line maximum tree
// A directed table and then random phases of inserts, queries and clears are
// streamed into the block across several domain settings. A node pool fill
// drives the pool-full case. Every result transfer is checked against an
// in-bench model of the tree, or a typed value of the directed table, with
// random gaps on the sender and stalls on the receiver.
// ----------------------------------------------------------------------------
module line_max_tree_tb;

    localparam longint INT_MIN   = -64'sd2147483648;
    localparam longint INT_MAX   = 64'sd2147483647;
    localparam longint ICPT_MIN  = -(64'sd1 <<< 60);
    localparam longint ICPT_MAX  = (64'sd1 <<< 60) - 1;
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        longint value;
        bit     full;
    } result_t;

    typedef struct {
        logic [1:0] func;
        longint     slope;
        longint     icpt;
        longint     x;
        bit         typed;
        longint     value;
        bit         full;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [lmt_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [lmt_pkg::M_DATA_W-1:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_addr = lmt_pkg::REG_DOMAIN_LOW;
    logic [31:0] cfg_data = '0;

    // Envelope model: node pool, domain registers and live root range
    longint env_slope [lmt_pkg::NODES];
    longint env_icpt  [lmt_pkg::NODES];
    int     env_left  [lmt_pkg::NODES];
    int     env_right [lmt_pkg::NODES];
    int     env_used;
    longint dom_lo = INT_MIN, dom_hi = INT_MAX;
    longint root_lo, root_hi;

    result_t results_due [$];
    int      fail_count = 0;
    int      idle_cycles = 0;
    int      burst_left = 0;

    line_max_tree dut (.*);

    always #4 aclk = ~aclk;

    function automatic longint line_val(longint a, longint b, longint x);
        return a * x + b;
    endfunction

    function automatic void env_node(int i);
        env_slope[i] = 0;
        env_icpt[i]  = lmt_pkg::EMPTY_B;
        env_left[i]  = 0;
        env_right[i] = 0;
    endfunction

    function automatic void env_clear();
        root_lo = dom_lo;
        root_hi = dom_hi;
        env_node(0);
        env_used = 1;
    endfunction

    // Insert walk; returns 1 when a needed child could not be allocated
    function automatic bit env_insert(longint a, longint b);
        int n, child;
        longint lo, hi, la, lb, ha, hb, t, m;
        bit right;
        n = 0; lo = root_lo; hi = root_hi;
        forever begin
            la = env_slope[n]; lb = env_icpt[n]; ha = a; hb = b;
            if (line_val(la, lb, lo) > line_val(ha, hb, lo)) begin
                t = la; la = ha; ha = t;
                t = lb; lb = hb; hb = t;
            end
            if (line_val(la, lb, hi) <= line_val(ha, hb, hi)) begin
                env_slope[n] = ha; env_icpt[n] = hb;
                return 1'b0;
            end
            m = (lo + hi) / 2;
            right = line_val(la, lb, m) < line_val(ha, hb, m);
            if (right) begin
                env_slope[n] = ha; env_icpt[n] = hb;
                a = la; b = lb; child = env_right[n];
            end else begin
                env_slope[n] = la; env_icpt[n] = lb;
                a = ha; b = hb; child = env_left[n];
            end
            if (child == 0) begin
                if (env_used >= lmt_pkg::NODES) return 1'b1;
                child = env_used++;
                env_node(child);
                if (right) env_right[n] = child;
                else env_left[n] = child;
            end
            if (right) lo = m + 1;
            else hi = m;
            n = child;
        end
    endfunction

    function automatic longint env_query(longint x);
        int n, child;
        longint lo, hi, m, v, best;
        n = 0; lo = root_lo; hi = root_hi; best = lmt_pkg::EMPTY_B;
        forever begin
            v = line_val(env_slope[n], env_icpt[n], x);
            m = (lo + hi) / 2;
            if (v > best) best = v;
            if (x <= m) begin
                child = env_left[n]; hi = m;
            end else begin
                child = env_right[n]; lo = m + 1;
            end
            if (child == 0 || child <= n || child >= lmt_pkg::NODES) return best;
            n = child;
        end
    endfunction

    function automatic result_t env_step(logic [1:0] func, longint a, longint b, longint x);
        result_t r;
        r.value = 0;
        r.full  = 1'b0;
        case (func)
            lmt_pkg::FUNC_INSERT: r.full = env_insert(a, b);
            lmt_pkg::FUNC_QUERY:  r.value = env_query(x);
            lmt_pkg::FUNC_CLEAR:  env_clear();
            default: ;
        endcase
        return r;
    endfunction

    // Sender: bursts of random length, random gaps in between
    task automatic send_op(logic [1:0] func, longint a, longint b, longint x,
                           bit typed = 1'b0, longint tv = 0, bit tf = 1'b0);
        result_t r;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, x[31:0], b[60:0], a[31:0], func};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = env_step(func, a, b, x);
        if (typed) begin
            r.value = tv;
            r.full  = tf;
        end
        results_due = {results_due, r};
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, longint val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val[31:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == lmt_pkg::REG_DOMAIN_LOW) dom_lo = val;
        else dom_hi = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic longint rand_icpt();
        longint v;
        if ($urandom_range(3) == 0) return longint'($urandom_range(0, 2000)) - 1000;
        v = {$urandom, $urandom};
        return (v <<< 3) >>> 3;
    endfunction

    function automatic longint rand_slope();
        if ($urandom_range(3) == 0) return longint'($urandom_range(0, 20)) - 10;
        return longint'(int'($urandom));
    endfunction

    function automatic longint rand_x();
        longint mn, mx, span;
        if ($urandom_range(9) == 0) return longint'(int'($urandom));
        mn = (root_lo < root_hi) ? root_lo : root_hi;
        mx = (root_lo < root_hi) ? root_hi : root_lo;
        span = mx - mn;
        return mn + (longint'($urandom) % (span + 1));
    endfunction

    // Random mix of operations over the current tree
    task automatic random_ops(int count);
        int k;
        logic [1:0] f;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(99);
            if (k < 45) f = lmt_pkg::FUNC_INSERT;
            else if (k < 88) f = lmt_pkg::FUNC_QUERY;
            else if (k < 94) f = lmt_pkg::FUNC_CLEAR;
            else f = FUNC_NONE;
            send_op(f, rand_slope(), rand_icpt(), rand_x());
        end
    endtask

    // Receiver stall pattern: random choice of always ready, random or mostly stalled
    int rx_mode = 0, rx_count = 0;
    always @(negedge aclk) begin
        rx_count <= rx_count + 1;
        if (rx_count % 300 == 299) rx_mode <= $urandom_range(2);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(1));
            default: m_tready <= ($urandom_range(7) == 0);
        endcase
    end

    // Result check against the oldest expectation
    always @(posedge aclk) begin
        result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result value=%0d status=%0d", $time,
                         $signed(m_tdata[63:0]), m_tdata[64]);
                fail_count++;
            end else begin
                e = results_due.pop_front();
                if ($signed(m_tdata[63:0]) != e.value) begin
                    $display("%0t: value expected %0d actual %0d", $time,
                             e.value, $signed(m_tdata[63:0]));
                    fail_count++;
                end
                if (m_tdata[64] != e.full) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             e.full, m_tdata[64]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    dir_row_t dir_tab [20] = '{
        '{lmt_pkg::FUNC_QUERY,  0, 0, 0, 1'b1, lmt_pkg::EMPTY_B, 1'b0},
        '{lmt_pkg::FUNC_QUERY,  0, 0, INT_MIN, 1'b1, lmt_pkg::EMPTY_B, 1'b0},
        '{FUNC_NONE,            -1, -1, -1, 1'b1, 0, 1'b0},
        '{lmt_pkg::FUNC_INSERT, INT_MAX, ICPT_MAX, 0, 1'b1, 0, 1'b0},
        '{lmt_pkg::FUNC_INSERT, INT_MIN, ICPT_MIN, 0, 1'b1, 0, 1'b0},
        '{lmt_pkg::FUNC_QUERY,  0, 0, INT_MAX, 1'b0, 0, 1'b0},
        '{lmt_pkg::FUNC_QUERY,  0, 0, INT_MIN, 1'b0, 0, 1'b0},
        '{lmt_pkg::FUNC_QUERY,  0, 0, 0, 1'b0, 0, 1'b0},
        '{lmt_pkg::FUNC_INSERT, 0, ICPT_MIN, 0, 1'b1, 0, 1'b0},
        '{lmt_pkg::FUNC_QUERY,  0, 0, -1, 1'b0, 0, 1'b0},
        '{lmt_pkg::FUNC_CLEAR,  0, 0, 0, 1'b1, 0, 1'b0},
        '{lmt_pkg::FUNC_INSERT, 0, 5, 0, 1'b1, 0, 1'b0},
        '{lmt_pkg::FUNC_QUERY,  0, 0, 12345, 1'b1, 5, 1'b0},
        '{lmt_pkg::FUNC_INSERT, -3, 0, 0, 1'b1, 0, 1'b0},
        '{lmt_pkg::FUNC_QUERY,  0, 0, -100, 1'b1, 300, 1'b0},
        '{lmt_pkg::FUNC_QUERY,  0, 0, 100, 1'b1, 5, 1'b0},
        // a line that falls below the empty value is reported as empty
        '{lmt_pkg::FUNC_CLEAR,  0, 0, 0, 1'b1, 0, 1'b0},
        '{lmt_pkg::FUNC_INSERT, INT_MIN, ICPT_MIN, 0, 1'b1, 0, 1'b0},
        '{lmt_pkg::FUNC_QUERY,  0, 0, INT_MAX, 1'b1, lmt_pkg::EMPTY_B, 1'b0},
        '{lmt_pkg::FUNC_QUERY,  0, 0, INT_MIN, 1'b0, 0, 1'b0}
    };

    longint phase_dom [6][2] = '{
        '{-8, 8}, '{5, -5}, '{INT_MAX, INT_MAX}, '{INT_MIN, INT_MIN},
        '{-1000, 1000}, '{INT_MIN, INT_MAX}
    };

    initial begin
        longint s;
        env_clear();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i])
            send_op(dir_tab[i].func, dir_tab[i].slope, dir_tab[i].icpt, dir_tab[i].x,
                    dir_tab[i].typed, dir_tab[i].value, dir_tab[i].full);
        drain();

        // Domain phases; new registers only matter once a clear is sent
        foreach (phase_dom[p]) begin
            write_reg(lmt_pkg::REG_DOMAIN_LOW, phase_dom[p][0]);
            write_reg(lmt_pkg::REG_DOMAIN_HIGH, phase_dom[p][1]);
            random_ops(5);
            send_op(lmt_pkg::FUNC_CLEAR, 0, 0, 0);
            random_ops(100);
            drain();
        end

        // Fill the pool with tangents of a parabola to reach the full pool
        send_op(lmt_pkg::FUNC_CLEAR, 0, 0, 0);
        for (int i = 0; i < 1150; i++) begin
            s = longint'($urandom_range(0, 2097152)) - 1048576;
            if ($urandom_range(19) == 0) send_op(lmt_pkg::FUNC_QUERY, 0, 0, rand_x());
            else send_op(lmt_pkg::FUNC_INSERT, 2 * s, -(s * s), 0);
        end
        random_ops(40);
        drain();

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
